[design/sv39_ptw_pkg.sv]
// Shared types and constants of the Sv39 page table walker.
`default_nettype none

package sv39_ptw_pkg;

  // Beat widths on the stream and configuration ports
  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 64;

  // Sv39 geometry
  localparam int unsigned VaBits   = 39;
  localparam int unsigned PpnBits  = 44;
  localparam int unsigned PaBits   = 56;
  localparam int unsigned VpnBits  = 9;
  localparam int unsigned PteOffW  = 3;
  localparam logic [1:0]  TopLevel = 2'd2;

  // Configuration register indexes (paddr[3])
  localparam logic RegTranslationOn = 1'b0;
  localparam logic RegRootTablePage = 1'b1;

  // Input beat kinds
  localparam logic ActRequest  = 1'b0;
  localparam logic ActPteReply = 1'b1;

  // Access kinds
  localparam logic [1:0] AccRead  = 2'd0;
  localparam logic [1:0] AccWrite = 2'd1;
  localparam logic [1:0] AccFetch = 2'd2;
  localparam logic [1:0] AccRsvd  = 2'd3;

  // Privilege levels
  localparam logic [1:0] PrivUser  = 2'd0;
  localparam logic [1:0] PrivSuper = 2'd1;
  localparam logic [1:0] PrivRsvd  = 2'd2;
  localparam logic [1:0] PrivMach  = 2'd3;

  typedef enum logic [1:0] {
    RES_FETCH_PTE = 2'd0,
    RES_DONE      = 2'd1,
    RES_FAULT     = 2'd2,
    RES_STRAY     = 2'd3
  } result_kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_INSTR = 2'd1,
    FAULT_LOAD  = 2'd2,
    FAULT_STORE = 2'd3
  } fault_code_e;

  // Status bits captured with a request
  typedef struct packed {
    logic [1:0] mpp;
    logic       mprv;
    logic       sum;
    logic       mxr;
  } status_t;

  // One result beat
  typedef struct packed {
    result_kind_e        kind;
    logic [PaBits-1:0]   pte_address;
    logic [63:0]         phys_addr;
    fault_code_e         fault;
    logic [1:0]          leaf_level;
  } result_t;

endpackage

`default_nettype wire

[design/sv39_page_table_walk.sv]
// Sv39 page table walker: request decode, PTE checks and output buffer.
// Each result beat is registered into the output buffer when its input beat is accepted.
// Throughput: one input beat per cycle while tready is high; each beat is fully
// handled by the combinational check and address step between the walk state and the
// two-entry output buffer, which keeps tready high while one result waits.
// Reset: asynchronous, active low; clears configuration, walk state and buffer.
`default_nettype none

module sv39_page_table_walk (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: virt_addr[63:0], access_kind[65:64], priv_level[67:66],
  //   make_exec_readable[68], supervisor_user_access[69], modify_privilege[70],
  //   previous_priv[72:71], physical_flag[73], pte_word[137:74], zero[143:138]
  input  logic [sv39_ptw_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: action[0]
  input  logic                                  s_axis_tuser,
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: pte_address[55:0], phys_addr[119:56], fault_code[121:120],
  //   leaf_level[123:122], zero[127:124]
  output logic [sv39_ptw_pkg::OutDataW-1:0]     m_axis_tdata,
  // tuser: result_kind[1:0]
  output logic [1:0]                            m_axis_tuser,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sv39_ptw_pkg::ApbAddrW-1:0]     paddr,
  input  logic [sv39_ptw_pkg::ApbDataW-1:0]     pwdata,
  output logic [sv39_ptw_pkg::ApbDataW-1:0]     prdata,
  output logic                                  pready
);

  // Configuration registers
  logic                                  trans_on_q;
  logic [sv39_ptw_pkg::PpnBits-1:0]      root_ppn_q;
  logic                                  cfg_wr;

  // Walk state
  logic                                  busy_q, busy_d;
  logic [1:0]                            level_q, level_d;
  logic [sv39_ptw_pkg::VaBits-1:0]       svaddr_q, svaddr_d;
  logic [1:0]                            skind_q, skind_d;
  logic [1:0]                            spriv_q, spriv_d;
  sv39_ptw_pkg::status_t                 sstat_q, sstat_d;

  // Output buffer
  logic                                  out_v_q, skid_v_q;
  sv39_ptw_pkg::result_t                 out_q, skid_q, res;
  logic                                  s_accept, m_take;

  // Input fields
  logic                                  in_action;
  logic [63:0]                           in_vaddr;
  logic [1:0]                            in_kind, in_priv, in_mpp;
  logic                                  in_mxr, in_sum, in_mprv, in_phys;
  logic [63:0]                           pte;

  // PTE decode
  logic                                  pte_v, pte_r, pte_w, pte_x, pte_u, pte_a, pte_d;
  logic [sv39_ptw_pkg::PpnBits-1:0]      ppn;
  logic [sv39_ptw_pkg::VpnBits-1:0]      vpn_next;
  logic                                  perm_bad, misaligned;
  logic [sv39_ptw_pkg::VpnBits-1:0]      pa_vpn0, pa_vpn1;
  sv39_ptw_pkg::fault_code_e             fault_code;

  // Unpack the input beat
  assign in_action = s_axis_tuser;
  assign in_vaddr  = s_axis_tdata[63:0];
  assign in_kind   = s_axis_tdata[65:64];
  assign in_priv   = s_axis_tdata[67:66];
  assign in_mxr    = s_axis_tdata[68];
  assign in_sum    = s_axis_tdata[69];
  assign in_mprv   = s_axis_tdata[70];
  assign in_mpp    = s_axis_tdata[72:71];
  assign in_phys   = s_axis_tdata[73];
  assign pte       = s_axis_tdata[137:74];

  assign pte_v = pte[0];
  assign pte_r = pte[1];
  assign pte_w = pte[2];
  assign pte_x = pte[3];
  assign pte_u = pte[4];
  assign pte_a = pte[6];
  assign pte_d = pte[7];
  assign ppn   = pte[53:10];

  // Handshakes
  assign s_axis_tready = !skid_v_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_take        = out_v_q && m_axis_tready;

  // Configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == sv39_ptw_pkg::RegRootTablePage)
                ? {{(sv39_ptw_pkg::ApbDataW - sv39_ptw_pkg::PpnBits){1'b0}}, root_ppn_q}
                : {{(sv39_ptw_pkg::ApbDataW - 1){1'b0}}, trans_on_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_on_q <= 1'b0;
      root_ppn_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == sv39_ptw_pkg::RegRootTablePage) begin
        root_ppn_q <= pwdata[sv39_ptw_pkg::PpnBits-1:0];
      end else begin
        trans_on_q <= pwdata[0];
      end
    end
  end

  // Pick the index field for the next table down
  always_comb begin
    unique case (level_q)
      2'd2:    vpn_next = svaddr_q[29:21];
      default: vpn_next = svaddr_q[20:12];
    endcase
  end

  // Fault code follows the saved access kind
  always_comb begin
    unique case (skind_q)
      sv39_ptw_pkg::AccFetch: fault_code = sv39_ptw_pkg::FAULT_INSTR;
      sv39_ptw_pkg::AccWrite: fault_code = sv39_ptw_pkg::FAULT_STORE;
      default:                fault_code = sv39_ptw_pkg::FAULT_LOAD;
    endcase
  end

  // Leaf permission and alignment checks
  always_comb begin
    perm_bad = 1'b0;
    if (skind_q == sv39_ptw_pkg::AccRead && !pte_r && !(sstat_q.mxr && pte_x)) perm_bad = 1'b1;
    if (skind_q == sv39_ptw_pkg::AccWrite && !pte_w) perm_bad = 1'b1;
    if (skind_q == sv39_ptw_pkg::AccFetch && !pte_x) perm_bad = 1'b1;
    if (!sstat_q.sum && pte_u && spriv_q == sv39_ptw_pkg::PrivSuper) perm_bad = 1'b1;
    if (!sstat_q.sum && pte_u && sstat_q.mprv && sstat_q.mpp == sv39_ptw_pkg::PrivSuper)
      perm_bad = 1'b1;
    if (!pte_u && spriv_q == sv39_ptw_pkg::PrivUser) perm_bad = 1'b1;
    misaligned = ((level_q != 2'd0) && (ppn[8:0] != '0)) ||
                 ((level_q == 2'd2) && (ppn[17:9] != '0));
    pa_vpn0 = (level_q != 2'd0) ? svaddr_q[20:12] : ppn[8:0];
    pa_vpn1 = (level_q == 2'd2) ? svaddr_q[29:21] : ppn[17:9];
  end

  // Handle one beat: next walk state and result
  always_comb begin
    busy_d   = busy_q;
    level_d  = level_q;
    svaddr_d = svaddr_q;
    skind_d  = skind_q;
    spriv_d  = spriv_q;
    sstat_d  = sstat_q;
    res      = '0;
    if (in_action == sv39_ptw_pkg::ActRequest) begin
      busy_d  = 1'b0;
      level_d = sv39_ptw_pkg::TopLevel;
      if (in_phys || !trans_on_q || in_priv == sv39_ptw_pkg::PrivMach) begin
        res.kind      = sv39_ptw_pkg::RES_DONE;
        res.phys_addr = in_vaddr;
      end else begin
        busy_d       = 1'b1;
        svaddr_d     = in_vaddr[sv39_ptw_pkg::VaBits-1:0];
        skind_d      = (in_kind == sv39_ptw_pkg::AccRsvd) ? sv39_ptw_pkg::AccRead : in_kind;
        spriv_d      = (in_priv == sv39_ptw_pkg::PrivRsvd) ? sv39_ptw_pkg::PrivSuper : in_priv;
        sstat_d      = '{mpp: in_mpp, mprv: in_mprv, sum: in_sum, mxr: in_mxr};
        res.kind        = sv39_ptw_pkg::RES_FETCH_PTE;
        res.pte_address = {root_ppn_q, in_vaddr[38:30], {sv39_ptw_pkg::PteOffW{1'b0}}};
      end
    end else if (!busy_q) begin
      res.kind = sv39_ptw_pkg::RES_STRAY;
    end else if (pte_v && !(!pte_r && pte_w) && !pte_r && !pte_x && level_q != 2'd0) begin
      // pointer entry: descend one level
      level_d         = level_q - 2'd1;
      res.kind        = sv39_ptw_pkg::RES_FETCH_PTE;
      res.pte_address = {ppn, vpn_next, {sv39_ptw_pkg::PteOffW{1'b0}}};
    end else if (!pte_v || !pte_r && pte_w || !pte_r && !pte_x || perm_bad || misaligned ||
                 !pte_a || (skind_q == sv39_ptw_pkg::AccWrite && !pte_d)) begin
      busy_d    = 1'b0;
      level_d   = sv39_ptw_pkg::TopLevel;
      res.kind  = sv39_ptw_pkg::RES_FAULT;
      res.fault = fault_code;
    end else begin
      busy_d         = 1'b0;
      level_d        = sv39_ptw_pkg::TopLevel;
      res.kind       = sv39_ptw_pkg::RES_DONE;
      res.phys_addr  = {8'd0, ppn[43:18], pa_vpn1, pa_vpn0, svaddr_q[11:0]};
      res.leaf_level = level_q;
    end
  end

  // Hold walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= sv39_ptw_pkg::TopLevel;
    end else if (s_accept) begin
      busy_q  <= busy_d;
      level_q <= level_d;
    end
  end

  // Hold the saved request fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svaddr_q <= '0;
      skind_q  <= sv39_ptw_pkg::AccRead;
      spriv_q  <= sv39_ptw_pkg::PrivUser;
      sstat_q  <= '0;
    end else if (s_accept) begin
      svaddr_q <= svaddr_d;
      skind_q  <= skind_d;
      spriv_q  <= spriv_d;
      sstat_q  <= sstat_d;
    end
  end

  // Output buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (s_accept) begin
      if (!out_v_q || m_take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (m_take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      if (!out_v_q || m_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (m_take && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'd0, out_q.leaf_level, out_q.fault, out_q.phys_addr,
                          out_q.pte_address};

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held while output register empty");

  a_idle_level_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> level_q == sv39_ptw_pkg::TopLevel)
    else $error("walk level not at top while idle");

  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(s_accept && in_action == sv39_ptw_pkg::ActRequest))
    else $error("walk started without a request beat");

  a_fault_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.kind == sv39_ptw_pkg::RES_FAULT |-> out_q.fault != sv39_ptw_pkg::FAULT_NONE)
    else $error("page fault result without a fault code");

endmodule

`default_nettype wire

[dv/sv39_page_table_walk_tb.sv]
// Self-checking testbench for the Sv39 page table walker: directed and random walks.
`timescale 1ns / 1ps

module sv39_page_table_walk_tb;

  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned CycleLimit    = 200000;

  // PTE flag bits
  localparam logic [7:0] PteV = 8'h01;
  localparam logic [7:0] PteR = 8'h02;
  localparam logic [7:0] PteW = 8'h04;
  localparam logic [7:0] PteX = 8'h08;
  localparam logic [7:0] PteU = 8'h10;
  localparam logic [7:0] PteG = 8'h20;
  localparam logic [7:0] PteA = 8'h40;
  localparam logic [7:0] PteD = 8'h80;

  // Input tdata layout, lowest field last
  typedef struct packed {
    logic [5:0]            pad;
    logic [63:0]           pte_word;
    logic                  physical;
    sv39_ptw_pkg::status_t status;
    logic [1:0]            priv;
    logic [1:0]            kind;
    logic [63:0]           vaddr;
  } walk_beat_t;

  typedef struct packed {
    logic       action;
    walk_beat_t body;
  } pending_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [sv39_ptw_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                              s_axis_tuser  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [sv39_ptw_pkg::OutDataW-1:0] m_axis_tdata;
  logic [1:0]                        m_axis_tuser;
  logic                              psel    = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite  = 1'b0;
  logic [sv39_ptw_pkg::ApbAddrW-1:0] paddr   = '0;
  logic [sv39_ptw_pkg::ApbDataW-1:0] pwdata  = '0;
  logic [sv39_ptw_pkg::ApbDataW-1:0] prdata;
  logic                              pready;

  // Walker shadow state and configuration
  logic                             xlate_on    = 1'b0;
  logic [sv39_ptw_pkg::PpnBits-1:0] root_ppn    = '0;
  logic                             walk_busy   = 1'b0;
  logic [1:0]                       walk_level  = sv39_ptw_pkg::TopLevel;
  logic [sv39_ptw_pkg::VaBits-1:0]  walk_va     = '0;
  logic [1:0]                       walk_kind   = sv39_ptw_pkg::AccRead;
  logic [1:0]                       walk_priv   = sv39_ptw_pkg::PrivUser;
  sv39_ptw_pkg::status_t            walk_status = '0;

  pending_t              pending_beats[$];
  sv39_ptw_pkg::result_t predicted_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req = 0;
  int stall_ack = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int gen_count = 0;
  int mismatch_count = 0;
  int beats_in = 0;
  int cfg_writes = 0;
  int kind_tally[4] = '{0, 0, 0, 0};

  sv39_page_table_walk dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pte_word_of(logic [43:0] ppn, logic [7:0] flags,
                                              logic [9:0] hi, logic [1:0] rsw);
    return {hi, ppn, rsw, flags};
  endfunction

  function automatic logic [sv39_ptw_pkg::PaBits-1:0] pte_slot(
      logic [sv39_ptw_pkg::PpnBits-1:0] ppn, logic [sv39_ptw_pkg::VaBits-1:0] va,
      logic [1:0] lvl);
    return {ppn, va[12 + 9 * lvl +: 9], 3'b000};
  endfunction

  function automatic walk_beat_t random_body();
    logic [159:0] raw;
    walk_beat_t   b;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    b = raw[143:0];
    b.pad = '0;
    return b;
  endfunction

  task automatic push_req(logic [63:0] va, logic [1:0] kind, logic [1:0] priv,
                          logic [4:0] st, logic phys);
    pending_t p;
    p.action        = sv39_ptw_pkg::ActRequest;
    p.body          = random_body();
    p.body.vaddr    = va;
    p.body.kind     = kind;
    p.body.priv     = priv;
    p.body.status   = st;
    p.body.physical = phys;
    pending_beats.push_back(p);
    gen_count++;
  endtask

  task automatic push_pte(logic [63:0] word);
    pending_t p;
    p.action        = sv39_ptw_pkg::ActPteReply;
    p.body          = random_body();
    p.body.pte_word = word;
    pending_beats.push_back(p);
    gen_count++;
  endtask

  // Work out the result of one accepted beat and advance the shadow walk
  task automatic sv39_translate(input logic action, input walk_beat_t b,
                                output sv39_ptw_pkg::result_t r);
    logic [sv39_ptw_pkg::PpnBits-1:0] ppn;
    logic [sv39_ptw_pkg::PaBits-1:0]  pa;
    logic v, rd, wr, ex, us, acc, dirty, fail;
    int lvl;
    r    = '0;
    fail = 1'b0;
    if (action == sv39_ptw_pkg::ActRequest) begin
      if (b.physical || !xlate_on || b.priv == sv39_ptw_pkg::PrivMach) begin
        walk_busy   = 1'b0;
        walk_level  = sv39_ptw_pkg::TopLevel;
        r.kind      = sv39_ptw_pkg::RES_DONE;
        r.phys_addr = b.vaddr;
      end else begin
        walk_kind     = (b.kind == sv39_ptw_pkg::AccRsvd) ? sv39_ptw_pkg::AccRead : b.kind;
        walk_priv     = (b.priv == sv39_ptw_pkg::PrivRsvd) ? sv39_ptw_pkg::PrivSuper : b.priv;
        walk_status   = b.status;
        walk_va       = b.vaddr[sv39_ptw_pkg::VaBits-1:0];
        walk_busy     = 1'b1;
        walk_level    = sv39_ptw_pkg::TopLevel;
        r.kind        = sv39_ptw_pkg::RES_FETCH_PTE;
        r.pte_address = pte_slot(root_ppn, walk_va, walk_level);
      end
    end else if (!walk_busy) begin
      r.kind = sv39_ptw_pkg::RES_STRAY;
    end else begin
      {dirty, acc} = b.pte_word[7:6];
      {us, ex, wr, rd, v} = b.pte_word[4:0];
      ppn = b.pte_word[53:10];
      lvl = walk_level;
      if (!v || (!rd && wr)) begin
        fail = 1'b1;
      end else if (!rd && !ex) begin
        // pointer to the next table down
        if (lvl == 0) begin
          fail = 1'b1;
        end else begin
          walk_level    = 2'(lvl - 1);
          r.kind        = sv39_ptw_pkg::RES_FETCH_PTE;
          r.pte_address = pte_slot(ppn, walk_va, walk_level);
        end
      end else begin
        if (walk_kind == sv39_ptw_pkg::AccRead && !rd && !(walk_status.mxr && ex))
          fail = 1'b1;
        if (walk_kind == sv39_ptw_pkg::AccWrite && !wr) fail = 1'b1;
        if (walk_kind == sv39_ptw_pkg::AccFetch && !ex) fail = 1'b1;
        if (!walk_status.sum && us && walk_priv == sv39_ptw_pkg::PrivSuper) fail = 1'b1;
        if (!walk_status.sum && us && walk_status.mprv &&
            walk_status.mpp == sv39_ptw_pkg::PrivSuper)
          fail = 1'b1;
        if (!us && walk_priv == sv39_ptw_pkg::PrivUser) fail = 1'b1;
        // superpage must be aligned to its size
        for (int k = 0; k < lvl; k++)
          if (ppn[9 * k +: 9] != '0) fail = 1'b1;
        if (!acc || (walk_kind == sv39_ptw_pkg::AccWrite && !dirty)) fail = 1'b1;
        if (!fail) begin
          pa[11:0] = walk_va[11:0];
          for (int k = 0; k < 2; k++)
            pa[12 + 9 * k +: 9] = (k < lvl) ? walk_va[12 + 9 * k +: 9] : ppn[9 * k +: 9];
          pa[55:30]    = ppn[43:18];
          walk_busy    = 1'b0;
          walk_level   = sv39_ptw_pkg::TopLevel;
          r.kind       = sv39_ptw_pkg::RES_DONE;
          r.phys_addr  = {8'd0, pa};
          r.leaf_level = lvl[1:0];
        end
      end
      if (fail) begin
        walk_busy  = 1'b0;
        walk_level = sv39_ptw_pkg::TopLevel;
        r.kind     = sv39_ptw_pkg::RES_FAULT;
        r.fault    = (walk_kind == sv39_ptw_pkg::AccFetch) ? sv39_ptw_pkg::FAULT_INSTR :
                     (walk_kind == sv39_ptw_pkg::AccWrite) ? sv39_ptw_pkg::FAULT_STORE :
                                                             sv39_ptw_pkg::FAULT_LOAD;
      end
    end
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
  endtask

  // One well-formed walk with random content, sometimes cut short
  task automatic queue_walk();
    logic [1:0]  kind, priv;
    logic [4:0]  st;
    logic [43:0] ppn;
    logic [7:0]  fl;
    logic        user_page;
    int          leaf_lvl, sent;
    kind = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 19) == 0) kind = sv39_ptw_pkg::AccRsvd;
    priv = $urandom_range(0, 1) ? sv39_ptw_pkg::PrivSuper : sv39_ptw_pkg::PrivUser;
    if ($urandom_range(0, 9) == 0) priv = sv39_ptw_pkg::PrivRsvd;
    st = 5'($urandom);
    push_req(rand64(), kind, priv, st, 1'b0);
    leaf_lvl = $urandom_range(0, 2);
    sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 - leaf_lvl) : 3;
    for (int lvl = 2; lvl >= leaf_lvl && (2 - lvl) < sent; lvl--) begin
      ppn = 44'(rand64());
      if (lvl > leaf_lvl || $urandom_range(0, 19) == 0) begin
        fl = PteV | 8'($urandom & (PteG | PteA | PteD | PteU));
        if ($urandom_range(0, 29) == 0) fl = 8'($urandom);
      end else begin
        fl = 8'($urandom & (PteR | PteW | PteX | PteG));
        if ($urandom_range(0, 6) != 0) begin
          case (kind)
            sv39_ptw_pkg::AccWrite: fl = fl | PteR | PteW;
            sv39_ptw_pkg::AccFetch: fl = fl | PteX;
            default:                fl = fl | PteR;
          endcase
        end
        user_page = (priv == sv39_ptw_pkg::PrivUser);
        if ($urandom_range(0, 6) == 0) user_page = !user_page;
        if (user_page) fl = fl | PteU;
        if ($urandom_range(0, 9) != 0) fl = fl | PteA;
        if ($urandom_range(0, 9) != 0) fl = fl | PteD;
        if ($urandom_range(0, 24) != 0) fl = fl | PteV;
        if (lvl > 0 && $urandom_range(0, 6) != 0) ppn = ppn >> (9 * lvl) << (9 * lvl);
      end
      push_pte(pte_word_of(ppn, fl, 10'($urandom), 2'($urandom)));
    end
  endtask

  // Mix walks, pass-through requests and stray replies
  task automatic queue_random(int count);
    int start;
    int sel;
    pending_t p;
    start = gen_count;
    while (gen_count - start < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 72) begin
        queue_walk();
      end else if (sel < 86) begin
        if ($urandom_range(0, 1))
          push_req(rand64(), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   5'($urandom), 1'b1);
        else
          push_req(rand64(), 2'($urandom_range(0, 3)), sv39_ptw_pkg::PrivMach,
                   5'($urandom), 1'b0);
      end else begin
        p.action        = sv39_ptw_pkg::ActPteReply;
        p.body          = random_body();
        p.body.pte_word = rand64();
        pending_beats.push_back(p);
        gen_count++;
      end
    end
  endtask

  task automatic apb_write(logic idx, logic [sv39_ptw_pkg::ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Offer the next pending beat once the current one has gone
  always @(posedge clk_i) begin : drive_input
    pending_t nxt;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.body;
        s_axis_tuser  <= nxt.action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Drive tready: random idling, or a long hold-off when asked for
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_req != stall_ack) begin
        stall_ack     <= stall_req;
        stall_left    <= HoldOffCycles;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Track register writes, predict each input beat, check each result beat
  always @(posedge clk_i) begin : monitor
    sv39_ptw_pkg::result_t want;
    walk_beat_t            seen;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        cfg_writes++;
        if (paddr[3] == sv39_ptw_pkg::RegRootTablePage)
          root_ppn = pwdata[sv39_ptw_pkg::PpnBits-1:0];
        else
          xlate_on = pwdata[0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen = s_axis_tdata;
        sv39_translate(s_axis_tuser, seen, want);
        predicted_results.push_back(want);
        beats_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result beat", m_axis_tdata[63:0], '0);
        end else begin
          want = predicted_results.pop_front();
          kind_tally[want.kind]++;
          if (m_axis_tuser !== want.kind)
            report_mismatch("result_kind", 64'(m_axis_tuser), 64'(want.kind));
          if (m_axis_tdata[55:0] !== want.pte_address)
            report_mismatch("pte_address", 64'(m_axis_tdata[55:0]), 64'(want.pte_address));
          if (m_axis_tdata[119:56] !== want.phys_addr)
            report_mismatch("phys_addr", m_axis_tdata[119:56], want.phys_addr);
          if (m_axis_tdata[121:120] !== want.fault)
            report_mismatch("fault_code", 64'(m_axis_tdata[121:120]), 64'(want.fault));
          if (m_axis_tdata[123:122] !== want.leaf_level)
            report_mismatch("leaf_level", 64'(m_axis_tdata[123:122]), 64'(want.leaf_level));
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_results.size());
      $display("FAIL sv39_page_table_walk");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sender sparse gaps, receiver mostly stalled
    send_idle_pct = 27;
    recv_idle_pct = 87;

    // Translation still off from reset: pass-through, then a stray reply
    push_req('1, sv39_ptw_pkg::AccFetch, sv39_ptw_pkg::PrivUser, '0, 1'b0);
    push_pte('1);
    wait_drained();

    apb_write(sv39_ptw_pkg::RegTranslationOn, 64'd1);
    apb_write(sv39_ptw_pkg::RegRootTablePage, '1);

    // Physical request and machine privilege bypass the walk
    push_req('0, sv39_ptw_pkg::AccWrite, sv39_ptw_pkg::PrivSuper, '0, 1'b1);
    push_req(rand64(), sv39_ptw_pkg::AccRead, sv39_ptw_pkg::PrivMach, '0, 1'b0);
    // 1 GiB read leaf at the root
    push_req(rand64(), sv39_ptw_pkg::AccRead, sv39_ptw_pkg::PrivSuper, '0, 1'b0);
    push_pte(pte_word_of(44'(rand64() << 18), PteV | PteR | PteA, '0, '0));
    // misaligned 2 MiB fetch leaf
    push_req(rand64(), sv39_ptw_pkg::AccFetch, sv39_ptw_pkg::PrivUser, '0, 1'b0);
    push_pte(pte_word_of('1, PteV, '1, '1));
    push_pte(pte_word_of(44'd1, PteV | PteX | PteU | PteA, '0, '0));
    // 4 KiB write leaf
    push_req(rand64(), sv39_ptw_pkg::AccWrite, sv39_ptw_pkg::PrivSuper, '0, 1'b0);
    push_pte(pte_word_of(44'(rand64()), PteV, '0, '0));
    push_pte(pte_word_of(44'(rand64()), PteV | PteA | PteD, '0, '0));
    push_pte(pte_word_of(44'(rand64()), PteV | PteR | PteW | PteA | PteD, '0, '0));
    // pointer entry at the last level
    push_req(rand64(), sv39_ptw_pkg::AccRead, sv39_ptw_pkg::PrivUser, '0, 1'b0);
    push_pte(pte_word_of(44'(rand64()), PteV, '0, '0));
    push_pte(pte_word_of(44'(rand64()), PteV, '0, '0));
    push_pte(pte_word_of(44'(rand64()), PteV, '0, '0));
    // new request drops a running walk; reserved kind under MPRV with MPP supervisor
    push_req(rand64(), sv39_ptw_pkg::AccRead, sv39_ptw_pkg::PrivSuper, '0, 1'b0);
    push_req(rand64(), sv39_ptw_pkg::AccRsvd, sv39_ptw_pkg::PrivUser, 5'b01100, 1'b0);
    push_pte(pte_word_of(44'(rand64() << 18), PteV | PteR | PteU | PteA, '0, '0));
    // execute-only page read with MXR
    push_req(rand64(), sv39_ptw_pkg::AccRead, sv39_ptw_pkg::PrivSuper, 5'b00001, 1'b0);
    push_pte(pte_word_of(44'(rand64() << 18), PteV | PteX | PteA, '0, '0));
    // write-without-read encoding, reserved privilege
    push_req(rand64(), sv39_ptw_pkg::AccWrite, sv39_ptw_pkg::PrivRsvd, '0, 1'b0);
    push_pte(pte_word_of(44'(rand64() << 18), PteV | PteW | PteA | PteD, '0, '0));
    wait_drained();

    apb_write(sv39_ptw_pkg::RegRootTablePage, rand64());
    queue_random(110);
    wait_drained();

    // Sender mostly idle, receiver sparse stalls
    send_idle_pct = 87;
    recv_idle_pct = 27;
    apb_write(sv39_ptw_pkg::RegRootTablePage, '0);
    queue_random(110);
    wait_drained();

    apb_write(sv39_ptw_pkg::RegTranslationOn, rand64() & ~64'd1);
    apb_write(sv39_ptw_pkg::RegRootTablePage, rand64());
    queue_random(30);
    wait_drained();

    // No idling; hold the result side off so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(sv39_ptw_pkg::RegTranslationOn, rand64() | 64'd1);
    apb_write(sv39_ptw_pkg::RegRootTablePage, '1);
    stall_req <= stall_req + 1;
    queue_random(60);
    wait_drained();

    apb_write(sv39_ptw_pkg::RegRootTablePage, rand64());
    queue_random(60);
    wait_drained();

    $display("Run covered %0d input beats: %0d PTE fetches, %0d done, %0d faults, %0d stray",
             beats_in, kind_tally[sv39_ptw_pkg::RES_FETCH_PTE],
             kind_tally[sv39_ptw_pkg::RES_DONE], kind_tally[sv39_ptw_pkg::RES_FAULT],
             kind_tally[sv39_ptw_pkg::RES_STRAY]);
    $display("%0d register writes, %0d field mismatches", cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS sv39_page_table_walk");
    end else begin
      $display("FAIL sv39_page_table_walk");
    end
    $finish;
  end

endmodule

[sim.f]
design/sv39_ptw_pkg.sv
design/sv39_page_table_walk.sv
dv/sv39_page_table_walk_tb.sv
